// File: src/voxel_column_occlusion_span_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel column occlusion span block
// Each macro expands to one labeled concurrent assertion on clock and reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_COLUMN_OCCLUSION_SPAN_MACROS_SVH
`define VOXEL_COLUMN_OCCLUSION_SPAN_MACROS_SVH

// same-cycle implication
`define VCOS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vcos check failed");

// next-cycle implication
`define VCOS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vcos check failed");

`endif

// File: src/vcos_pkg.sv
// ----------------------------------------------------------------------------
// vcos_pkg
// Shared types and constants of the voxel column occlusion span block.
// ----------------------------------------------------------------------------
package vcos_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON_ROW   = 2'd1;

   // configuration reset values
   localparam logic signed [10:0] HEIGHT_OFFSET_RESET = -11'sd120;
   localparam logic signed [10:0] HORIZON_ROW_RESET   = 11'sd100;

   // item kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // input transaction
   typedef struct packed {
      logic               req_type;
      logic signed [23:0] map_x;
      logic signed [23:0] map_y;
      logic [9:0]         column;
      logic signed [23:0] scale;
      logic               first_line;
      logic [7:0]         load_height;
      logic [23:0]        load_color;
   } vcos_req_type;

   // result transaction
   typedef struct packed {
      logic [9:0]  span_column;
      logic [8:0]  span_top;
      logic [9:0]  span_bottom;
      logic [23:0] span_color;
   } vcos_rsp_type;

endpackage

// File: src/vcos_wrap.sv
// ----------------------------------------------------------------------------
// vcos_wrap
// Two-stage map coordinate unit: floors a Q15.8 position and wraps it into
// 0..MAP_DIM-1 by a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module vcos_wrap #(
   parameter int MAP_DIM = 1024
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic signed [23:0]         pos,
   output logic [$clog2(MAP_DIM)-1:0] cell_idx
);

   localparam int AW    = $clog2(MAP_DIM);
   localparam int ADJ   = MAP_DIM - (32768 % MAP_DIM);
   localparam int RECIP = (1 << 17) / MAP_DIM;
   localparam int RW    = $clog2(RECIP + 1);
   localparam int PW    = 17 + RW;

   logic [16:0]    v_in;
   logic [16:0]    v_ff;
   logic [PW-1:0]  prod_in;
   logic [PW-1:0]  prod_ff;
   logic [RW-1:0]  quot;
   logic [16:0]    quot_dim;
   logic [16:0]    rem;
   logic [16:0]    rem_fix;
   logic [AW-1:0]  idx_in;
   logic [AW-1:0]  idx_ff;

   // floor plus 32768 bias, shifted so the remainder is the true modulo
   assign v_in    = 17'({~pos[23], pos[22:8]}) + 17'(ADJ);
   assign prod_in = PW'(v_in) * PW'(RECIP);

   // quotient estimate is low by at most one
   assign quot     = prod_ff[PW-1:17];
   assign quot_dim = 17'(32'(quot) * 32'(MAP_DIM));
   assign rem      = v_ff - quot_dim;
   assign rem_fix  = (rem >= 17'(MAP_DIM)) ? (rem - 17'(MAP_DIM)) : rem;
   assign idx_in   = rem_fix[AW-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff    <= v_in;
         prod_ff <= prod_in;
         idx_ff  <= idx_in;
      end
   end

   assign cell_idx = idx_ff;

endmodule

// File: src/voxel_column_occlusion_span.sv
// Path: a sample's span is registered in each pipeline stage, then in the output register.
// Throughput: one transaction per cycle while rsp_ready is high; the y-buffer
//   read-modify-write spans two stages and is forwarded between neighbors.
// Reset: clears control state, then sweeps each of the SCREEN_COLS y-buffer entries
//   with req_ready low; configuration writes are taken throughout.
// Map contents are undefined until loaded.
// ----------------------------------------------------------------------------
// voxel_column_occlusion_span
// Terrain map store, perspective projection and per-column occlusion buffer
// producing vertical fill spans for a front-to-back voxel renderer.
// ----------------------------------------------------------------------------
module voxel_column_occlusion_span #(
   parameter int MAP_DIM     = 1024,
   parameter int SCREEN_COLS = 700,
   parameter int SCREEN_ROWS = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  vcos_pkg::vcos_req_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output vcos_pkg::vcos_rsp_type          rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vcos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [10:0]                     csr_wdata
);

   localparam int AW    = $clog2(MAP_DIM);
   localparam int YAW   = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
   localparam int MAP_DEPTH = 1 << (2 * AW);
   localparam logic [23:0] ROWS_Q8 = 24'(SCREEN_ROWS * 256);
   localparam logic signed [16:0] ROWS_ROW = 17'(SCREEN_ROWS);

   // configuration
   logic signed [10:0] height_offset_ff;
   logic signed [10:0] horizon_row_ff;

   // flow control
   logic adv;
   logic req_fire;

   // y-buffer clearing pass
   logic           clr_busy_ff;
   logic [YAW-1:0] clr_idx_ff;

   // stage 1
   logic        s1_valid_ff;
   logic        s1_sample_ff;
   logic [9:0]  s1_col_ff;
   logic [23:0] s1_scale_ff;
   logic        s1_first_ff;
   logic [31:0] s1_cell_ff;

   // stage 2
   logic        s2_valid_ff;
   logic        s2_sample_ff;
   logic        s2_col_ok_ff;
   logic [9:0]  s2_col_ff;
   logic [23:0] s2_scale_ff;
   logic        s2_first_ff;
   logic [31:0] s2_cell_ff;
   logic [AW-1:0] xi;
   logic [AW-1:0] yi;
   logic [2*AW-1:0] map_addr;

   // stage 3
   logic        s3_valid_ff;
   logic [9:0]  s3_col_ff;
   logic [23:0] s3_scale_ff;
   logic        s3_first_ff;
   logic [31:0] map_rd_ff;
   logic signed [11:0] hsum;
   logic signed [35:0] prod_in;

   // stage 4
   logic        s4_valid_ff;
   logic [9:0]  s4_col_ff;
   logic        s4_first_ff;
   logic [23:0] s4_color_ff;
   logic signed [35:0] s4_prod_ff;
   logic [23:0] yb_rd_ff;
   logic        fwd_hit_ff;
   logic [23:0] fwd_data_ff;

   logic signed [28:0] top_sum;
   logic signed [23:0] top_q8;
   logic signed [23:0] entry_q8;
   logic signed [23:0] yb_new;
   logic signed [16:0] row_top;
   logic signed [16:0] row_bot;
   logic signed [16:0] row_top_c;
   logic signed [16:0] row_bot_c;
   logic        emit;
   logic        fwd_hit_in;

   // output register
   logic                   rsp_valid_ff;
   vcos_pkg::vcos_rsp_type rsp_data_ff;

   // memories
   logic [31:0] map_mem [MAP_DEPTH];
   logic [23:0] yb_mem  [SCREEN_COLS];
   logic [YAW-1:0] yb_rd_addr;
   logic [YAW-1:0] yb_wr_addr;
   logic [23:0]    yb_wr_data;
   logic           yb_wr_en;

   // pipeline moves unless a result waits unread
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clr_busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         height_offset_ff <= vcos_pkg::HEIGHT_OFFSET_RESET;
         horizon_row_ff   <= vcos_pkg::HORIZON_ROW_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vcos_pkg::CSR_HEIGHT_OFFSET: height_offset_ff <= csr_wdata;
            vcos_pkg::CSR_HORIZON_ROW:   horizon_row_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == YAW'(SCREEN_COLS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // map coordinate units
   vcos_wrap #(.MAP_DIM(MAP_DIM)) u_wrap_x (
      .clock    (clock),
      .enable   (adv),
      .pos      (req_data.map_x),
      .cell_idx (xi)
   );

   vcos_wrap #(.MAP_DIM(MAP_DIM)) u_wrap_y (
      .clock    (clock),
      .enable   (adv),
      .pos      (req_data.map_y),
      .cell_idx (yi)
   );

   assign map_addr = {xi, yi};

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_sample_ff && s2_col_ok_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff <= req_data.req_type;
         s1_col_ff    <= req_data.column;
         s1_scale_ff  <= req_data.scale;
         s1_first_ff  <= req_data.first_line;
         s1_cell_ff   <= {req_data.load_height, req_data.load_color};

         s2_sample_ff <= s1_sample_ff;
         s2_col_ok_ff <= (32'(s1_col_ff) < 32'(SCREEN_COLS));
         s2_col_ff    <= s1_col_ff;
         s2_scale_ff  <= s1_scale_ff;
         s2_first_ff  <= s1_first_ff;
         s2_cell_ff   <= s1_cell_ff;

         s3_col_ff    <= s2_col_ff;
         s3_scale_ff  <= s2_scale_ff;
         s3_first_ff  <= s2_first_ff;

         s4_col_ff    <= s3_col_ff;
         s4_first_ff  <= s3_first_ff;
         s4_color_ff  <= map_rd_ff[23:0];
         s4_prod_ff   <= prod_in;
      end
   end

   // map store: loads write and samples read at the same stage
   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         if (s2_sample_ff == vcos_pkg::REQ_LOAD) begin
            map_mem[map_addr] <= s2_cell_ff;
         end else if (s2_col_ok_ff) begin
            map_rd_ff <= map_mem[map_addr];
         end
      end
   end

   // height plus offset, times scale
   assign hsum    = 12'($signed({4'b0000, map_rd_ff[31:24]})) + 12'(height_offset_ff);
   assign prod_in = 36'(hsum) * 36'($signed(s3_scale_ff));

   // projected top in Q15.8 with saturation
   assign top_sum = 29'($signed(s4_prod_ff[35:8])) + 29'($signed({horizon_row_ff, 8'h00}));
   always_comb begin
      if (top_sum > 29'sd8388607) begin
         top_q8 = 24'sh7FFFFF;
      end else if (top_sum < -29'sd8388608) begin
         top_q8 = 24'sh800000;
      end else begin
         top_q8 = top_sum[23:0];
      end
   end

   // y-buffer entry, with the previous stage-4 write forwarded
   always_comb begin
      if (s4_first_ff) begin
         entry_q8 = ROWS_Q8;
      end else if (fwd_hit_ff) begin
         entry_q8 = fwd_data_ff;
      end else begin
         entry_q8 = yb_rd_ff;
      end
   end

   // clipped span rows
   assign row_top   = 17'($signed(top_q8[23:8]));
   assign row_bot   = 17'($signed(entry_q8[23:8]));
   assign row_top_c = (row_top < 17'sd0) ? 17'sd0 : row_top;
   assign row_bot_c = (row_bot > ROWS_ROW) ? ROWS_ROW : row_bot;
   assign emit      = row_top_c < row_bot_c;
   assign yb_new    = (top_q8 < entry_q8) ? top_q8 : entry_q8;

   // y-buffer ports
   assign yb_rd_addr = YAW'(s3_col_ff);
   always_comb begin
      if (clr_busy_ff) begin
         yb_wr_en   = 1'b1;
         yb_wr_addr = clr_idx_ff;
         yb_wr_data = ROWS_Q8;
      end else begin
         yb_wr_en   = adv && s4_valid_ff;
         yb_wr_addr = YAW'(s4_col_ff);
         yb_wr_data = yb_new;
      end
   end
   assign fwd_hit_in = s4_valid_ff && s3_valid_ff && (s4_col_ff == s3_col_ff);

   always_ff @(posedge clock) begin
      if (yb_wr_en) begin
         yb_mem[yb_wr_addr] <= yb_wr_data;
      end
      if (adv && s3_valid_ff) begin
         yb_rd_ff <= yb_mem[yb_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (adv) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_data_ff <= yb_new;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.span_column <= s4_col_ff;
         rsp_data_ff.span_top    <= row_top_c[8:0];
         rsp_data_ff.span_bottom <= row_bot_c[9:0];
         rsp_data_ff.span_color  <= s4_color_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/vcos_checker.sv
// ----------------------------------------------------------------------------
// vcos_checker
// Port-level checks of the voxel column occlusion span block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "voxel_column_occlusion_span_macros.svh"

module vcos_checker #(
   parameter int SCREEN_COLS = 700,
   parameter int SCREEN_ROWS = 512
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input vcos_pkg::vcos_rsp_type rsp_data
);

   // a stalled result transaction holds
   `VCOS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // every span covers at least one row within the screen
   `VCOS_ASSERT_IMP(a_span_nonempty, rsp_valid, (SCREEN_ROWS > 511) || ((rsp_data.span_top < 9'(SCREEN_ROWS)) && (rsp_data.span_bottom <= 10'(SCREEN_ROWS)) && (10'(rsp_data.span_top) < rsp_data.span_bottom)))

   // spans only for columns on screen
   `VCOS_ASSERT_IMP(a_span_column, rsp_valid, (SCREEN_COLS > 1023) || (rsp_data.span_column < 10'(SCREEN_COLS)))

   // the clearing pass holds off input right after reset
   `VCOS_ASSERT_IMP(a_clear_blocks, $past(reset), !req_ready)

   // no result can appear while input is still blocked after reset
   `VCOS_ASSERT_IMP(a_no_early_rsp, $past(reset) && !req_valid, !rsp_valid)

endmodule

bind voxel_column_occlusion_span vcos_checker #(
   .SCREEN_COLS (SCREEN_COLS),
   .SCREEN_ROWS (SCREEN_ROWS)
) u_vcos_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/voxel_column_occlusion_span_test.sv
// ----------------------------------------------------------------------------
// voxel_column_occlusion_span_test
// Self-checking bench for the voxel column occlusion span block. It loads
// terrain cells, streams column samples along depth lines, keeps its own
// copy of the map, y-buffer and projection registers, and checks every span
// transaction field by field against its own projection, under several
// register settings and rates of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module voxel_column_occlusion_span_test;

   localparam int MAP_DIM       = 1024;
   localparam int SCREEN_COLS   = 700;
   localparam int SCREEN_ROWS   = 512;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 10;
   localparam longint Q8_LOW    = -64'sd8388608;
   localparam longint Q8_HIGH   = 64'sd8388607;
   localparam logic [23:0] POS_LOW  = 24'h800000;
   localparam logic [23:0] POS_HIGH = 24'h7FFFFF;
   localparam logic [23:0] SCALE_MIN = 24'h800000;
   localparam logic [23:0] SCALE_MAX = 24'h7FFFFF;
   localparam logic [23:0] SCALE_ONE = 24'h010000;
   localparam logic [23:0] SCALE_NEG_ONE = 24'hFF0000;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   vcos_pkg::vcos_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   vcos_pkg::vcos_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vcos_pkg::CSR_IDX_W-1:0] csr_index = vcos_pkg::CSR_HEIGHT_OFFSET;
   logic [10:0] csr_wdata = '0;

   // predictor state
   logic [31:0] terrain_cells [int];
   int loaded_cells [$];
   int ybuffer [SCREEN_COLS] = '{default: SCREEN_ROWS * 256};
   logic signed [10:0] height_offset = vcos_pkg::HEIGHT_OFFSET_RESET;
   logic signed [10:0] horizon_row = vcos_pkg::HORIZON_ROW_RESET;
   vcos_pkg::vcos_rsp_type expected_spans [$];

   int span_errors = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int idle_cycles = 0;

   voxel_column_occlusion_span #(
      .MAP_DIM(MAP_DIM),
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor of a Q15.8 position, wrapped to the map
   function automatic int map_wrap(input logic signed [23:0] pos);
      int coord;
      coord = int'(pos >>> 8);
      return ((coord % MAP_DIM) + MAP_DIM) % MAP_DIM;
   endfunction

   // random Q15.8 position whose wrapped floor is coord
   function automatic logic [23:0] cell_position(input int coord);
      int wraps;
      logic [31:0] whole;
      wraps = int'($urandom_range(0, 65535 / MAP_DIM)) - 32768 / MAP_DIM;
      whole = coord + MAP_DIM * wraps;
      return {whole[15:0], 8'($urandom)};
   endfunction

   // projection and occlusion of one accepted transaction
   function automatic void project_column(input vcos_pkg::vcos_req_type item);
      int cell_idx;
      logic [31:0] cell_word;
      longint entry, top, row_top, row_bot, hsum;
      vcos_pkg::vcos_rsp_type span;
      cell_idx = map_wrap(item.map_x) * MAP_DIM + map_wrap(item.map_y);
      if (item.req_type == vcos_pkg::REQ_LOAD) begin
         if (!terrain_cells.exists(cell_idx))
            loaded_cells.push_back(cell_idx);
         terrain_cells[cell_idx] = {item.load_height, item.load_color};
         return;
      end
      if (item.column >= SCREEN_COLS)
         return;
      cell_word = terrain_cells[cell_idx];
      entry = item.first_line ? longint'(SCREEN_ROWS) * 256 : longint'(ybuffer[item.column]);
      hsum = longint'(cell_word[31:24]) + longint'(height_offset);
      top = ((hsum * longint'($signed(item.scale))) >>> 8) + longint'(horizon_row) * 256;
      if (top < Q8_LOW) top = Q8_LOW;
      if (top > Q8_HIGH) top = Q8_HIGH;
      row_top = top >>> 8;
      row_bot = entry >>> 8;
      if (row_top < 0) row_top = 0;
      if (row_bot > SCREEN_ROWS) row_bot = SCREEN_ROWS;
      ybuffer[item.column] = int'((top < entry) ? top : entry);
      if (row_top < row_bot) begin
         span.span_column = item.column;
         span.span_top    = 9'(row_top);
         span.span_bottom = 10'(row_bot);
         span.span_color  = cell_word[23:0];
         expected_spans.push_back(span);
      end
   endfunction

   // every bit random; callers pin down what matters
   function automatic vcos_pkg::vcos_req_type any_request();
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      return noise[$bits(vcos_pkg::vcos_req_type)-1:0];
   endfunction

   function automatic vcos_pkg::vcos_req_type aim_at_loaded_cell(
         input vcos_pkg::vcos_req_type item);
      int cell_idx;
      cell_idx = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
      item.map_x = cell_position(cell_idx / MAP_DIM);
      item.map_y = cell_position(cell_idx % MAP_DIM);
      return item;
   endfunction

   function automatic vcos_pkg::vcos_req_type load_item(input logic [23:0] x,
                                                        input logic [23:0] y,
                                                        input logic [7:0] height,
                                                        input logic [23:0] color);
      vcos_pkg::vcos_req_type item;
      item = any_request();
      item.req_type = vcos_pkg::REQ_LOAD;
      item.map_x = x;
      item.map_y = y;
      item.load_height = height;
      item.load_color = color;
      return item;
   endfunction

   function automatic vcos_pkg::vcos_req_type sample_item(input logic [23:0] x,
                                                          input logic [23:0] y,
                                                          input logic [9:0] column,
                                                          input logic [23:0] scale,
                                                          input logic first_line);
      vcos_pkg::vcos_req_type item;
      item = any_request();
      item.req_type = vcos_pkg::REQ_SAMPLE;
      item.map_x = x;
      item.map_y = y;
      item.column = column;
      item.scale = scale;
      item.first_line = first_line;
      return item;
   endfunction

   // one request transaction; valid stays up across back-to-back sends
   task automatic send_request(input vcos_pkg::vcos_req_type item);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      project_column(item);
   endtask

   // hold the sender until every expected span is back
   task automatic wait_for_spans();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_spans.size() != 0);
   endtask

   // both registers, written only with the block idle
   task automatic set_projection(input logic signed [10:0] offset,
                                 input logic signed [10:0] horizon);
      wait_for_spans();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= vcos_pkg::CSR_HEIGHT_OFFSET;
      csr_wdata <= offset;
      do @(posedge clock); while (!csr_ready);
      height_offset = offset;
      csr_index <= vcos_pkg::CSR_HORIZON_ROW;
      csr_wdata <= horizon;
      do @(posedge clock); while (!csr_ready);
      horizon_row = horizon;
      csr_valid <= 1'b0;
   endtask

   // mix of loads, depth-line sweeps and loose samples
   task automatic run_terrain_traffic(input int n_items);
      int sent, pick, first_col, n_cols, n_lines, depth, step;
      vcos_pkg::vcos_req_type item;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 15 || loaded_cells.size() == 0) begin
            item = any_request();
            if ($urandom_range(0, 3) == 0 && loaded_cells.size() != 0)
               item = aim_at_loaded_cell(item);
            item.req_type = vcos_pkg::REQ_LOAD;
            send_request(item);
            sent++;
         end else if (pick < 75) begin
            // front-to-back sweep over a few neighboring columns
            n_cols = $urandom_range(1, 8);
            first_col = $urandom_range(0, SCREEN_COLS - 1);
            n_lines = $urandom_range(2, 6);
            depth = $urandom_range(2, 20);
            step = $urandom_range(1, 8);
            for (int line = 0; line < n_lines; line++) begin
               for (int c = 0; c < n_cols; c++) begin
                  item = aim_at_loaded_cell(any_request());
                  item.req_type = vcos_pkg::REQ_SAMPLE;
                  item.column = 10'(first_col + c);
                  item.first_line = (line == 0);
                  item.scale = 24'(-15728640 / depth);
                  send_request(item);
                  sent++;
               end
               depth += step;
            end
         end else if (pick < 98) begin
            item = aim_at_loaded_cell(any_request());
            item.req_type = vcos_pkg::REQ_SAMPLE;
            if ($urandom_range(0, 3) != 0)
               item.column = 10'($urandom_range(0, SCREEN_COLS - 1));
            send_request(item);
            sent++;
         end else begin
            wait_for_spans();
         end
      end
   endtask

   task automatic test_directed_cases();
      // three cells, two of them at the corners of the position range
      send_request(load_item(POS_LOW, POS_HIGH, 8'hFF, 24'hFFFFFF));
      send_request(load_item(POS_HIGH, POS_LOW, 8'h00, 24'h000000));
      send_request(load_item(24'h0001FF, 24'hFFFF00, 8'd200, 24'hA5C35A));
      // first line on column 0, full-height span
      send_request(sample_item(POS_LOW, POS_HIGH, 10'd0, SCALE_NEG_ONE, 1'b1));
      // lower terrain behind it on column 0 is occluded: empty span; column 699 still gets one
      send_request(sample_item(POS_HIGH, POS_LOW, 10'd0, SCALE_NEG_ONE, 1'b0));
      send_request(sample_item(POS_HIGH, POS_LOW, 10'd699, SCALE_NEG_ONE, 1'b0));
      // columns past the screen edge
      send_request(sample_item(POS_LOW, POS_HIGH, 10'd700, SCALE_NEG_ONE, 1'b0));
      send_request(sample_item(POS_LOW, POS_HIGH, 10'd1023, SCALE_NEG_ONE, 1'b1));
      // scale extremes
      send_request(sample_item(POS_LOW, POS_HIGH, 10'd699, SCALE_MAX, 1'b0));
      send_request(sample_item(POS_LOW, POS_HIGH, 10'd1, SCALE_MIN, 1'b1));
      // zero scale puts the top on the horizon
      send_request(sample_item(24'h0001FF, 24'hFFFF00, 10'd2, 24'h000000, 1'b0));
      send_request(sample_item(24'h0001FF, 24'hFFFF00, 10'd2, 24'h000000, 1'b1));
      send_request(sample_item(24'h0001FF, 24'hFFFF00, 10'd2, SCALE_NEG_ONE, 1'b0));
   endtask

   task automatic test_register_extremes();
      logic signed [10:0] offsets [6];
      logic signed [10:0] horizons [6];
      offsets = '{-11'sd1023, 11'sd1023, 11'sd0, 11'sd1023, -11'sd1023, 11'($urandom)};
      horizons = '{-11'sd1024, 11'sd1023, 11'sd0, -11'sd1024, 11'sd1023, 11'($urandom)};
      if (offsets[5] == -11'sd1024)
         offsets[5] = -11'sd1023;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      foreach (offsets[i]) begin
         set_projection(offsets[i], horizons[i]);
         // scale extremes, which saturate on both sides unless the offset is small, then flat ground
         send_request(sample_item(POS_LOW, POS_HIGH, 10'($urandom_range(0, SCREEN_COLS - 1)),
                                  SCALE_MAX, 1'b1));
         send_request(sample_item(POS_LOW, POS_HIGH, 10'($urandom_range(0, SCREEN_COLS - 1)),
                                  SCALE_MIN, 1'b1));
         send_request(sample_item(POS_HIGH, POS_LOW, 10'($urandom_range(0, SCREEN_COLS - 1)),
                                  SCALE_ONE, 1'b0));
         run_terrain_traffic(30);
      end
   endtask

   task automatic test_random_traffic(input logic signed [10:0] offset,
                                      input logic signed [10:0] horizon,
                                      input int gap_pct, input int stall_pct,
                                      input int n_items);
      set_projection(offset, horizon);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      run_terrain_traffic(n_items);
   endtask

   // receiver back-pressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   function automatic void report_span_error(input string what, input logic [31:0] want,
                                             input logic [31:0] got);
      span_errors++;
      if (span_errors <= MAX_REPORTS)
         $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
   endfunction

   // compare each span transaction with the oldest expectation
   always @(posedge clock) begin : span_check
      vcos_pkg::vcos_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_spans.size() == 0) begin
            report_span_error("unexpected span, column", '1, 32'(rsp_data.span_column));
         end else begin
            want = expected_spans.pop_front();
            if (rsp_data.span_column !== want.span_column)
               report_span_error("span_column", 32'(want.span_column),
                                 32'(rsp_data.span_column));
            if (rsp_data.span_top !== want.span_top)
               report_span_error("span_top", 32'(want.span_top), 32'(rsp_data.span_top));
            if (rsp_data.span_bottom !== want.span_bottom)
               report_span_error("span_bottom", 32'(want.span_bottom),
                                 32'(rsp_data.span_bottom));
            if (rsp_data.span_color !== want.span_color)
               report_span_error("span_color", 32'(want.span_color),
                                 32'(rsp_data.span_color));
         end
      end
   end

   // watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("voxel_column_occlusion_span_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_traffic(-11'sd120, 11'sd100, 0, 0, 400);
      test_random_traffic(-11'sd60, 11'sd150, 70, 0, 400);
      test_random_traffic(11'($urandom), 11'($urandom_range(0, 1023)), 0, 70, 400);
      test_random_traffic(-11'sd200, 11'sd40, 37, 37, 400);
      wait_for_spans();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (span_errors == 0)
         $display("voxel_column_occlusion_span_test: PASS");
      else
         $display("voxel_column_occlusion_span_test: FAIL");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/vcos_pkg.sv
src/vcos_wrap.sv
src/voxel_column_occlusion_span.sv
src/vcos_checker.sv
tb/voxel_column_occlusion_span_test.sv
